// ----- hdl/psvt_pkg.sv -----
// ----------------------------------------------------------------------------
// psvt_pkg
// Types and codes shared by the sorted vector table modules.
// ----------------------------------------------------------------------------
package psvt_pkg;

	localparam logic [1:0] KIND_SLOT   = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_DISP   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic FUNC_REG  = 1'b0;
	localparam logic FUNC_DISP = 1'b1;

	localparam logic [7:0] PRIO_MASK = 8'h7f;

	typedef struct packed {
		logic        func;
		logic [4:0]  line;
		logic [31:0] handler_addr;
		logic [7:0]  priority_in;
		logic [31:0] enabled_mask;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic        slot_enable;
		logic [4:0]  slot_line;
		logic [31:0] addr_out;
		logic [4:0]  position;
		logic [1:0]  status;
		logic        found;
		logic        last;
	} out_item_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic        func;
		logic        zero_addr;
		logic [4:0]  line;
		logic [6:0]  prio;
		logic [31:0] addr;
		logic [31:0] mask;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [4:0]  line;
		logic [6:0]  prio;
		logic [31:0] addr;
	} entry_t;

endpackage

// ----- hdl/psvt_front.sv -----
// ----------------------------------------------------------------------------
// psvt_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module psvt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  psvt_pkg::in_item_t in_data,
	output logic              q_valid,
	output psvt_pkg::cmd_t    q_data,
	input  logic              q_pop
);
	import psvt_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       push;

	always_comb begin
		cmd.func      = in_data.func;
		cmd.zero_addr = (in_data.handler_addr == 32'd0);
		cmd.line      = in_data.line;
		cmd.prio      = 7'(in_data.priority_in & PRIO_MASK);
		cmd.addr      = in_data.handler_addr;
		cmd.mask      = in_data.enabled_mask;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- hdl/psvt_back.sv -----
// ----------------------------------------------------------------------------
// psvt_back
// Holds the sorted table and carries out register and dispatch commands.
// ----------------------------------------------------------------------------
module psvt_back #(
	parameter int TABLE_ENTRIES = 32,
	parameter int VECTOR_SLOTS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  psvt_pkg::cmd_t     q_data,
	output logic               q_pop,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output psvt_pkg::out_item_t out_data
);
	import psvt_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] N_IDX    = CW'(TABLE_ENTRIES);
	localparam logic [CW-1:0] VS_IDX   = (VECTOR_SLOTS >= TABLE_ENTRIES) ?
	                                     CW'(TABLE_ENTRIES) : CW'(VECTOR_SLOTS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_MOVE = 6'b000100,
		S_PUT  = 6'b001000,
		S_STAT = 6'b010000,
		S_DISP = 6'b100000
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	entry_t      tab_q [TABLE_ENTRIES];
	logic [CW-1:0] i_q, hit_q, ins_q;
	logic        hit_fnd_q, ins_fnd_q, down_q;
	logic [1:0]  st_q;
	logic [31:0] dummy_q;
	logic        out_valid_q;
	out_item_t   out_q;

	entry_t      cur, src_e, new_e;
	logic [CW-1:0] src_idx, hit_n, ins_n;
	logic        hit_fnd_n, ins_fnd_n, out_free, emit, wr_en;
	logic        cur_slot, ins_slot;
	out_item_t   res;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cur     = tab_q[i_q[IW-1:0]];
	assign src_idx = down_q ? (i_q - CW'(1)) : (i_q + CW'(1));
	assign src_e   = tab_q[src_idx[IW-1:0]];
	assign cur_slot = (32'(i_q) < VECTOR_SLOTS);
	assign ins_slot = (32'(ins_q) < VECTOR_SLOTS);

	always_comb begin
		new_e.valid = 1'b1;
		new_e.line  = cmd_q.line;
		new_e.prio  = cmd_q.prio;
		new_e.addr  = cmd_q.addr;
	end

	// Running first-match search for the line hit and the insert point.
	always_comb begin
		hit_n     = hit_q;
		hit_fnd_n = hit_fnd_q;
		ins_n     = ins_q;
		ins_fnd_n = ins_fnd_q;
		if (!hit_fnd_q && (!cur.valid || cur.line == cmd_q.line)) begin
			hit_n     = i_q;
			hit_fnd_n = 1'b1;
		end
		if (!ins_fnd_q && (!cur.valid || cur.prio < cmd_q.prio)) begin
			ins_n     = i_q;
			ins_fnd_n = 1'b1;
		end
	end

	function automatic out_item_t slot_item(input entry_t e, input logic [CW-1:0] idx,
	                                        input logic [31:0] dummy);
		out_item_t r;
		r             = '0;
		r.kind        = KIND_SLOT;
		r.slot        = 4'(idx);
		r.slot_enable = e.valid;
		r.slot_line   = e.valid ? e.line : 5'd0;
		r.addr_out    = e.valid ? e.addr : dummy;
		return r;
	endfunction

	always_comb begin
		emit  = 1'b0;
		wr_en = 1'b0;
		q_pop = 1'b0;
		res   = '0;
		unique case (state_q)
			S_IDLE: q_pop = q_valid;
			S_MOVE: begin
				if (i_q != ins_q) begin
					emit  = cur_slot;
					wr_en = !cur_slot || out_free;
					res   = slot_item(src_e, i_q, dummy_q);
				end
			end
			S_PUT: begin
				emit  = ins_slot;
				wr_en = !ins_slot || out_free;
				res   = slot_item(new_e, ins_q, dummy_q);
			end
			S_STAT: begin
				emit       = 1'b1;
				res.kind   = KIND_STATUS;
				res.status = st_q;
				res.position = (st_q == ST_OK) ? 5'(ins_q) : 5'd0;
				res.last   = 1'b1;
			end
			S_DISP: begin
				if (i_q >= N_IDX) begin
					emit         = 1'b1;
					res.kind     = KIND_DISP;
					res.addr_out = dummy_q;
					res.last     = 1'b1;
				end else if (cur.valid && cmd_q.mask[cur.line]) begin
					emit         = 1'b1;
					res.kind     = KIND_DISP;
					res.addr_out = cur.addr;
					res.found    = 1'b1;
					res.last     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (emit && out_free) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			dummy_q     <= 32'd0;
			i_q         <= '0;
			hit_q       <= '0;
			ins_q       <= '0;
			hit_fnd_q   <= 1'b0;
			ins_fnd_q   <= 1'b0;
			down_q      <= 1'b0;
			st_q        <= ST_OK;
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				tab_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				dummy_q <= cfg_data;
			end
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						hit_fnd_q <= 1'b0;
						ins_fnd_q <= 1'b0;
						hit_q     <= N_IDX;
						ins_q     <= N_IDX;
						if (q_data.func == FUNC_DISP) begin
							i_q     <= VS_IDX;
							state_q <= S_DISP;
						end else if (q_data.zero_addr) begin
							st_q    <= ST_ZERO;
							state_q <= S_STAT;
						end else begin
							i_q     <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					hit_q     <= hit_n;
					hit_fnd_q <= hit_fnd_n;
					ins_q     <= ins_n;
					ins_fnd_q <= ins_fnd_n;
					if (i_q == LAST_IDX) begin
						if (!hit_fnd_n) begin
							st_q    <= ST_FULL;
							state_q <= S_STAT;
						end else begin
							i_q     <= hit_n;
							down_q  <= (hit_n > ins_n);
							if (ins_n > hit_n) begin
								ins_q <= ins_n - CW'(1);
							end
							state_q <= S_MOVE;
						end
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_MOVE: begin
					if (i_q == ins_q) begin
						state_q <= S_PUT;
					end else if (wr_en) begin
						tab_q[i_q[IW-1:0]] <= src_e;
						i_q <= src_idx;
					end
				end
				S_PUT: begin
					if (wr_en) begin
						tab_q[ins_q[IW-1:0]] <= new_e;
						st_q    <= ST_OK;
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DISP: begin
					if (emit) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/priority_sorted_vector_table.sv -----
// ----------------------------------------------------------------------------
// priority_sorted_vector_table
// Sorted interrupt handler table with vector slot updates and dispatch.
// ----------------------------------------------------------------------------
// A register request scans the whole table for the line hit and the insert
// point, shifts the entries between them one at a time, writes the new entry
// and reports a status; a zero handler goes straight to the status. A dispatch
// walks one entry per cycle from VECTOR_SLOTS up to the first match or to the
// end of the table, then reports the match or the dummy handler. A two-entry
// queue lets input transfers continue while the back end works, and an output
// register holds a result.
module priority_sorted_vector_table #(
	parameter int TABLE_ENTRIES = 32,
	parameter int VECTOR_SLOTS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  psvt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output psvt_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import psvt_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_data;

	psvt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	psvt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.VECTOR_SLOTS  (VECTOR_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- sim/priority_sorted_vector_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_vector_table_tb
// Drives handler registrations and dispatches into the sorted vector table,
// predicts slot writes, status and dispatch answers, and checks every result.
// ----------------------------------------------------------------------------
module priority_sorted_vector_table_tb;
	import psvt_pkg::*;

	localparam int ENTRIES   = 32;
	localparam int SLOTS     = 16;
	localparam int IDLE_PCT  = 31;
	localparam int CYCLE_CAP = 400000;
	localparam int HOLD_OFF  = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	priority_sorted_vector_table #(
		.TABLE_ENTRIES(ENTRIES),
		.VECTOR_SLOTS (SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Predicted table contents and the dummy handler.
	entry_t      shadow_table [ENTRIES];
	logic [31:0] shadow_dummy;

	in_item_t  pending_requests [$];
	out_item_t expected_results [$];
	int        error_count;
	int        cycle_count;
	logic      calm_phase;     // no random idling on either side
	logic      hold_off_go;    // asks the receiver for one long hold-off
	int        hold_off_left;  // long receiver hold-off, in cycles
	logic      hold_off_used;
	logic      driving;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	function automatic out_item_t slot_write(input int idx);
		out_item_t r;
		r = '0;
		r.kind = KIND_SLOT;
		r.slot = idx[3:0];
		if (shadow_table[idx].valid) begin
			r.slot_enable = 1'b1;
			r.slot_line   = shadow_table[idx].line;
			r.addr_out    = shadow_table[idx].addr;
		end else begin
			r.addr_out = shadow_dummy;
		end
		return r;
	endfunction

	// Works out the results of one request and updates the shadow table.
	task automatic predict_table_update(input in_item_t req);
		out_item_t r;
		int hit;
		int ins;
		logic [6:0] prio;
		hit  = ENTRIES;
		ins  = ENTRIES;
		prio = req.priority_in[6:0];
		r    = '0;
		r.last = 1'b1;
		if (req.func == FUNC_DISP) begin
			r.kind     = KIND_DISP;
			r.addr_out = shadow_dummy;
			for (int i = SLOTS; i < ENTRIES; i++) begin
				if (shadow_table[i].valid && req.enabled_mask[shadow_table[i].line]) begin
					r.addr_out = shadow_table[i].addr;
					r.found    = 1'b1;
					break;
				end
			end
			expected_results.push_back(r);
			return;
		end
		r.kind = KIND_STATUS;
		if (req.handler_addr == 32'd0) begin
			r.status = ST_ZERO;
			expected_results.push_back(r);
			return;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit == ENTRIES && (!shadow_table[i].valid || shadow_table[i].line == req.line))
				hit = i;
			if (ins == ENTRIES && (!shadow_table[i].valid || shadow_table[i].prio < prio))
				ins = i;
		end
		if (hit == ENTRIES) begin
			r.status = ST_FULL;
			expected_results.push_back(r);
			return;
		end
		if (hit > ins) begin
			for (int i = hit; i > ins; i--) begin
				shadow_table[i] = shadow_table[i-1];
				if (i < SLOTS)
					expected_results.push_back(slot_write(i));
			end
		end else if (ins > hit) begin
			ins--;
			for (int i = hit; i < ins; i++) begin
				shadow_table[i] = shadow_table[i+1];
				if (i < SLOTS)
					expected_results.push_back(slot_write(i));
			end
		end
		shadow_table[ins] = '{valid: 1'b1, line: req.line, prio: prio, addr: req.handler_addr};
		if (ins < SLOTS)
			expected_results.push_back(slot_write(ins));
		r.position = ins[4:0];
		expected_results.push_back(r);
	endtask

	// Driver: offers queued requests, keeping a stalled payload steady.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (pending_requests.size() > 0 && driving &&
					(calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data  <= pending_requests.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Prediction happens at the accepting edge, in order.
	always @(posedge clk) begin
		if (arst_n === 1'b0) begin
			for (int i = 0; i < ENTRIES; i++)
				shadow_table[i] = '0;
		end else if (arst_n && in_valid && !in_stall)
			predict_table_update(in_data);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall     <= 1'b0;
			hold_off_left <= 0;
			hold_off_used <= 1'b0;
		end else if (hold_off_go && !hold_off_used) begin
			out_stall     <= 1'b1;
			hold_off_left <= HOLD_OFF - 1;
			hold_off_used <= 1'b1;
		end else if (hold_off_left > 0) begin
			out_stall     <= 1'b1;
			hold_off_left <= hold_off_left - 1;
		end else
			out_stall <= !calm_phase && ($urandom_range(99) < IDLE_PCT);
	end

	// Monitor: compares every result transfer with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_data[31:0], 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.kind != want.kind)
					report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
				if (out_data.slot != want.slot)
					report_mismatch("slot", 32'(out_data.slot), 32'(want.slot));
				if (out_data.slot_enable != want.slot_enable)
					report_mismatch("slot_enable", 32'(out_data.slot_enable),
						32'(want.slot_enable));
				if (out_data.slot_line != want.slot_line)
					report_mismatch("slot_line", 32'(out_data.slot_line),
						32'(want.slot_line));
				if (out_data.addr_out != want.addr_out)
					report_mismatch("addr_out", out_data.addr_out, want.addr_out);
				if (out_data.position != want.position)
					report_mismatch("position", 32'(out_data.position),
						32'(want.position));
				if (out_data.status != want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.found != want.found)
					report_mismatch("found", 32'(out_data.found), 32'(want.found));
				if (out_data.last != want.last)
					report_mismatch("last", 32'(out_data.last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("priority_sorted_vector_table_tb: done, errors");
			$finish;
		end
	end

	function automatic in_item_t make_request(input logic func, input logic [4:0] line,
			input logic [31:0] addr, input logic [7:0] prio, input logic [31:0] mask);
		in_item_t it;
		it.func         = func;
		it.line         = line;
		it.handler_addr = addr;
		it.priority_in  = prio;
		it.enabled_mask = mask;
		return it;
	endfunction

	function automatic logic [31:0] rand_addr();
		return $urandom_range(9) == 0 ? 32'd0 : $urandom();
	endfunction

	// Lets the block finish, then writes the dummy handler on an idle port.
	task automatic settle_and_configure(input logic [31:0] value);
		wait (pending_requests.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (80) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		shadow_dummy = value;
	endtask

	task automatic random_phase(input int count, input int line_span);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 30)
				pending_requests.push_back(make_request(FUNC_DISP, 5'($urandom()),
					$urandom(), 8'($urandom()),
					$urandom_range(3) == 0 ? 32'd0 : $urandom()));
			else
				pending_requests.push_back(make_request(FUNC_REG,
					5'($urandom_range(line_span)), rand_addr(),
					$urandom_range(3) == 0 ? 8'($urandom_range(3)) : 8'($urandom()),
					$urandom()));
		end
	endtask

	initial begin
		calm_phase    = 1'b0;
		hold_off_go   = 1'b0;
		driving       = 1'b1;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		shadow_dummy  = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		settle_and_configure(32'hffff_ffff);
		// Directed: empty dispatch, zero handler, extremes, ties, re-registration.
		pending_requests.push_back(make_request(FUNC_DISP, 5'd0, 32'd0, 8'd0, 32'hffff_ffff));
		pending_requests.push_back(make_request(FUNC_REG, 5'd3, 32'd0, 8'd50, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd0, 32'hffff_ffff, 8'hff, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd31, 32'd1, 8'd0, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd5, 32'h5555_5555, 8'h80, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd6, 32'haaaa_aaaa, 8'h80, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd5, 32'h1234_5678, 8'd0, 32'd0));
		pending_requests.push_back(make_request(FUNC_REG, 5'd0, 32'h0bad_f00d, 8'd127, 32'd0));
		// Fill every entry so dispatch reaches the upper half and the table fills.
		for (int l = 1; l < 31; l++)
			pending_requests.push_back(make_request(FUNC_REG, l[4:0], 32'h100 + l,
				8'(l * 3), 32'd0));
		pending_requests.push_back(make_request(FUNC_DISP, 5'd0, 32'd0, 8'd0, 32'hffff_ffff));
		pending_requests.push_back(make_request(FUNC_DISP, 5'd0, 32'd0, 8'd0, 32'h0000_0000));
		settle_and_configure(32'h0000_0000);
		pending_requests.push_back(make_request(FUNC_REG, 5'd31, 32'h77, 8'd0, 32'd0));
		pending_requests.push_back(make_request(FUNC_DISP, 5'd31, 32'h0, 8'h0, 32'h8000_0001));
		pending_requests.push_back(make_request(FUNC_DISP, 5'd0, 32'd0, 8'd0, 32'h0));

		// Long hold-off on the receiver while requests keep coming.
		hold_off_go = 1'b1;
		random_phase(40, 31);
		settle_and_configure($urandom());

		calm_phase = 1'b1;
		random_phase(50, 31);
		wait (pending_requests.size() == 0);
		calm_phase = 1'b0;
		settle_and_configure(32'h8000_0001);

		random_phase(80, 31);
		wait (pending_requests.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("priority_sorted_vector_table_tb: done, clean");
		else
			$display("priority_sorted_vector_table_tb: done, errors");
		$finish;
	end

endmodule
